// ----- design/hsv2rgb_pkg.sv -----
// Shared constants and types for the HSV to RGB converter.
// Depends on nothing; used by hsv_to_rgb_converter.
`default_nettype none

package hsv2rgb_pkg;

	localparam int FRAC_BITS = 12;
	localparam int CHAN_W = 13;
	localparam int HUE_W = 13;
	localparam int REM_W = 10;
	localparam int SEC_W = 3;
	localparam int PROD_W = 2 * CHAN_W;

	localparam logic [CHAN_W-1:0] ONE = CHAN_W'(1) << FRAC_BITS;
	localparam int HUE_SECTOR = 960;
	localparam logic [HUE_W-1:0] HUE_FULL = HUE_W'(6 * HUE_SECTOR);

	localparam int FF_SHIFT = 13;
	localparam int FF_MULT_W = 16;
	localparam int FF_PROD_W = REM_W + FF_MULT_W;
	localparam logic [FF_MULT_W-1:0] FF_MULT =
		FF_MULT_W'(((64'd1 << (FRAC_BITS + FF_SHIFT)) + HUE_SECTOR - 1) / HUE_SECTOR);

	typedef enum logic [SEC_W-1:0] {
		SEC_RED     = 3'd0,
		SEC_YELLOW  = 3'd1,
		SEC_GREEN   = 3'd2,
		SEC_CYAN    = 3'd3,
		SEC_BLUE    = 3'd4,
		SEC_MAGENTA = 3'd5
	} sector_t;

	function automatic logic [HUE_W-1:0] sector_base(input sector_t sec);
		logic [HUE_W-1:0] base;
		base = HUE_W'(HUE_SECTOR) * HUE_W'(sec);
		return base;
	endfunction

endpackage

`default_nettype wire

// ----- design/hsv_to_rgb_converter.sv -----
// Five-stage pipelined HSV to RGB converter with 4096-as-one fixed point.
// Depends on hsv2rgb_pkg for widths, constants and the sector type.
//
//   channel | direction | handshake         | payload
//   command | in        | start, busy       | hue, saturation, brightness
//   result  | out       | done (one cycle)  | red, green, blue
//
// A beat is taken on every cycle with start high; busy never rises.
// Each result appears with done once its command beat has passed through every stage.
// The rate is one beat per cycle, since every stage passes its beat on each cycle;
// the five register stages of the datapath set the latency.
// Reset clears only the valid bits of the pipeline.
`default_nettype none

module hsv_to_rgb_converter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [hsv2rgb_pkg::HUE_W-1:0]    hue,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0]   saturation,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0]   brightness,
	output logic                             done,
	output logic [hsv2rgb_pkg::CHAN_W-1:0]   red,
	output logic [hsv2rgb_pkg::CHAN_W-1:0]   green,
	output logic [hsv2rgb_pkg::CHAN_W-1:0]   blue
);
	import hsv2rgb_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	logic [HUE_W-1:0]  hue_c;
	logic [CHAN_W-1:0] sat_c, val_c;
	sector_t           sector_c;
	logic [HUE_W-1:0]  rem_c;

	sector_t           sector_s1, sector_s2, sector_s3, sector_s4;
	logic [REM_W-1:0]  rem_s1;
	logic [CHAN_W-1:0] sat_s1, val_s1, sat_s2, val_s2, val_s3, val_s4;
	logic [FRAC_BITS-1:0] ff_s2;
	logic [CHAN_W-1:0] p_s2, p_s3, p_s4;
	logic [CHAN_W-1:0] sff_s3, sffc_s3;
	logic [CHAN_W-1:0] q_s4, t_s4;
	logic [CHAN_W-1:0] red_s5, green_s5, blue_s5;

	logic [FF_PROD_W-1:0] ff_prod;
	logic [PROD_W-1:0]    p_prod, sff_prod, sffc_prod, q_prod, t_prod;

	assign busy = 1'b0;

	always_comb begin
		hue_c = (hue >= HUE_FULL) ? '0 : hue;
		sat_c = (saturation > ONE) ? ONE : saturation;
		val_c = (brightness > ONE) ? ONE : brightness;
		if (hue_c >= sector_base(SEC_MAGENTA)) begin
			sector_c = SEC_MAGENTA;
		end else if (hue_c >= sector_base(SEC_BLUE)) begin
			sector_c = SEC_BLUE;
		end else if (hue_c >= sector_base(SEC_CYAN)) begin
			sector_c = SEC_CYAN;
		end else if (hue_c >= sector_base(SEC_GREEN)) begin
			sector_c = SEC_GREEN;
		end else if (hue_c >= sector_base(SEC_YELLOW)) begin
			sector_c = SEC_YELLOW;
		end else begin
			sector_c = SEC_RED;
		end
		rem_c = hue_c - sector_base(sector_c);
	end

	assign ff_prod   = FF_PROD_W'(rem_s1) * FF_PROD_W'(FF_MULT);
	assign p_prod    = PROD_W'(val_s1) * PROD_W'(ONE - sat_s1);
	assign sff_prod  = PROD_W'(sat_s2) * PROD_W'(ff_s2);
	assign sffc_prod = PROD_W'(sat_s2) * PROD_W'(ONE - CHAN_W'(ff_s2));
	assign q_prod    = PROD_W'(val_s3) * PROD_W'(ONE - sff_s3);
	assign t_prod    = PROD_W'(val_s3) * PROD_W'(ONE - sffc_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		sector_s1 <= sector_c;
		rem_s1    <= rem_c[REM_W-1:0];
		sat_s1    <= sat_c;
		val_s1    <= val_c;

		sector_s2 <= sector_s1;
		ff_s2     <= ff_prod[FF_SHIFT +: FRAC_BITS];
		p_s2      <= p_prod[FRAC_BITS +: CHAN_W];
		sat_s2    <= sat_s1;
		val_s2    <= val_s1;

		sector_s3 <= sector_s2;
		sff_s3    <= sff_prod[FRAC_BITS +: CHAN_W];
		sffc_s3   <= sffc_prod[FRAC_BITS +: CHAN_W];
		p_s3      <= p_s2;
		val_s3    <= val_s2;

		sector_s4 <= sector_s3;
		q_s4      <= q_prod[FRAC_BITS +: CHAN_W];
		t_s4      <= t_prod[FRAC_BITS +: CHAN_W];
		p_s4      <= p_s3;
		val_s4    <= val_s3;

		case (sector_s4)
			SEC_RED: begin
				red_s5 <= val_s4; green_s5 <= t_s4; blue_s5 <= p_s4;
			end
			SEC_YELLOW: begin
				red_s5 <= q_s4; green_s5 <= val_s4; blue_s5 <= p_s4;
			end
			SEC_GREEN: begin
				red_s5 <= p_s4; green_s5 <= val_s4; blue_s5 <= t_s4;
			end
			SEC_CYAN: begin
				red_s5 <= p_s4; green_s5 <= q_s4; blue_s5 <= val_s4;
			end
			SEC_BLUE: begin
				red_s5 <= t_s4; green_s5 <= p_s4; blue_s5 <= val_s4;
			end
			default: begin
				red_s5 <= val_s4; green_s5 <= p_s4; blue_s5 <= q_s4;
			end
		endcase
	end

	assign done  = valid_s5;
	assign red   = red_s5;
	assign green = green_s5;
	assign blue  = blue_s5;

`ifndef SYNTHESIS
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (rem_s1 < REM_W'(HUE_SECTOR)) && (sector_s1 <= SEC_MAGENTA))
		else $error("hue remainder or sector out of range");

	a_ff_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (p_s2 <= val_s2) && (val_s2 <= ONE))
		else $error("p shade exceeds value");

	a_shades: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> (q_s4 <= val_s4) && (t_s4 <= val_s4) && (p_s4 <= val_s4))
		else $error("q or t shade exceeds value");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (red <= ONE) && (green <= ONE) && (blue <= ONE))
		else $error("result channel above one");
`endif

endmodule

`default_nettype wire

// ----- bench/hsv_to_rgb_converter_checker.sv -----
`timescale 1ns / 1ps
// Checker for the HSV to RGB converter: watches the command and result ports,
// predicts each color and compares it with the result that comes back.
// Depends on hsv2rgb_pkg for widths, fixed-point constants and the sector type.

module hsv_to_rgb_converter_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic [hsv2rgb_pkg::HUE_W-1:0]  hue,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0] saturation,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0] brightness,
	input  logic                           done,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0] red,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0] green,
	input  logic [hsv2rgb_pkg::CHAN_W-1:0] blue,
	output int                             errors,
	output int                             pending,
	output int                             results_checked
);
	import hsv2rgb_pkg::*;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	rgb_t rgb_expected_q[$];

	initial begin
		errors = 0;
		pending = 0;
		results_checked = 0;
	end

	function automatic rgb_t convert_hsv(input logic [HUE_W-1:0] h_in,
			input logic [CHAN_W-1:0] s_in, input logic [CHAN_W-1:0] v_in);
		logic [31:0] h;
		logic [31:0] s;
		logic [31:0] v;
		logic [31:0] ff;
		logic [CHAN_W-1:0] vc;
		logic [CHAN_W-1:0] pc;
		logic [CHAN_W-1:0] qc;
		logic [CHAN_W-1:0] tc;
		sector_t sec;
		rgb_t c;
		h = h_in;
		s = (s_in > ONE) ? 32'(ONE) : 32'(s_in);
		v = (v_in > ONE) ? 32'(ONE) : 32'(v_in);
		if (h >= HUE_FULL)
			h = 0;
		vc = CHAN_W'(v);
		if (s == 0) begin
			c = '{vc, vc, vc};
		end else begin
			sec = sector_t'(SEC_W'(h / HUE_SECTOR));
			ff = ((h % HUE_SECTOR) * 32'(ONE)) / HUE_SECTOR;
			pc = CHAN_W'((v * (32'(ONE) - s)) >> FRAC_BITS);
			qc = CHAN_W'((v * (32'(ONE) - ((s * ff) >> FRAC_BITS))) >> FRAC_BITS);
			tc = CHAN_W'((v * (32'(ONE) - ((s * (32'(ONE) - ff)) >> FRAC_BITS)))
				>> FRAC_BITS);
			case (sec)
				SEC_RED:     c = '{vc, tc, pc};
				SEC_YELLOW:  c = '{qc, vc, pc};
				SEC_GREEN:   c = '{pc, vc, tc};
				SEC_CYAN:    c = '{pc, qc, vc};
				SEC_BLUE:    c = '{tc, pc, vc};
				default:     c = '{vc, pc, qc};
			endcase
		end
		return c;
	endfunction

	task automatic check_channel(input string name, input logic [CHAN_W-1:0] expected,
			input logic [CHAN_W-1:0] actual);
		if (actual !== expected) begin
			$error("%s mismatch: expected %0d, got %0d", name, expected, actual);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		rgb_t want;
		if (arst_n) begin
			if (done) begin
				if (rgb_expected_q.size() == 0) begin
					$error("Result beat with no color outstanding: red %0d green %0d blue %0d",
						red, green, blue);
					errors++;
				end else begin
					want = rgb_expected_q.pop_front();
					check_channel("red", want.red, red);
					check_channel("green", want.green, green);
					check_channel("blue", want.blue, blue);
					results_checked++;
				end
			end
			if (start && !busy)
				rgb_expected_q.push_back(convert_hsv(hue, saturation, brightness));
			pending <= rgb_expected_q.size();
		end
	end

endmodule

// ----- bench/hsv_to_rgb_converter_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the HSV to RGB converter: drives directed and random colors
// with random idle bursts and reports the verdict.
// Depends on hsv2rgb_pkg, hsv_to_rgb_converter and hsv_to_rgb_converter_checker.

module hsv_to_rgb_converter_tb;
	import hsv2rgb_pkg::*;

	localparam int RANDOM_ITEMS = 1500;
	localparam int QUIET_TAIL = 200;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 10;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [HUE_W-1:0]  hue = '0;
	logic [CHAN_W-1:0] saturation = '0;
	logic [CHAN_W-1:0] brightness = '0;
	logic              done;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;

	int errors;
	int pending;
	int results_checked;
	int colors_sent = 0;
	int stall_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	hsv_to_rgb_converter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.done       (done),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	hsv_to_rgb_converter_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.hue             (hue),
		.saturation      (saturation),
		.brightness      (brightness),
		.done            (done),
		.red             (red),
		.green           (green),
		.blue            (blue),
		.errors          (errors),
		.pending         (pending),
		.results_checked (results_checked)
	);

	function automatic logic [HUE_W-1:0] pick_hue();
		case ($urandom_range(0, 9))
			7:       return HUE_W'($urandom_range(HUE_FULL, (1 << HUE_W) - 1));
			8:       return HUE_W'($urandom_range(1, 6) * HUE_SECTOR + $urandom_range(0, 2) - 1);
			9:       return HUE_W'($urandom);
			default: return HUE_W'($urandom_range(0, HUE_FULL - 1));
		endcase
	endfunction

	function automatic logic [CHAN_W-1:0] pick_level();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return ONE;
			2:       return CHAN_W'($urandom_range(ONE + 1, (1 << CHAN_W) - 1));
			3:       return CHAN_W'($urandom);
			default: return CHAN_W'($urandom_range(0, ONE));
		endcase
	endfunction

	task automatic send_color(input logic [HUE_W-1:0] h, input logic [CHAN_W-1:0] s,
			input logic [CHAN_W-1:0] v);
		start <= 1'b1;
		hue <= h;
		saturation <= s;
		brightness <= v;
		do
			@(posedge clk);
		while (busy);
		colors_sent++;
	endtask

	task automatic idle_for(input int cycles);
		start <= 1'b0;
		hue <= HUE_W'($urandom);
		saturation <= CHAN_W'($urandom);
		brightness <= CHAN_W'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("Timeout: no beat on either channel for %0d cycles", STALL_LIMIT);
				$display("FAILURE");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		int i;
		bit quiet;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sector edges, wrapped hues, zero saturation and clamped inputs.
		send_color(13'd0,    13'd4096, 13'd4096);
		send_color(13'd959,  13'd4096, 13'd4096);
		send_color(13'd960,  13'd4096, 13'd4096);
		send_color(13'd1919, 13'd2048, 13'd4096);
		send_color(13'd1920, 13'd4096, 13'd3000);
		send_color(13'd2880, 13'd4096, 13'd4096);
		send_color(13'd3840, 13'd1000, 13'd4096);
		send_color(13'd4800, 13'd4096, 13'd4096);
		send_color(13'd5759, 13'd4096, 13'd4096);
		send_color(13'd5760, 13'd4096, 13'd4096);
		send_color(13'd8191, 13'd4096, 13'd2048);
		send_color(13'd480,  13'd0,    13'd4096);
		send_color(13'd480,  13'd0,    13'd8191);
		send_color(13'd480,  13'd0,    13'd0);
		send_color(13'd100,  13'd0,    13'd4095);
		send_color(13'd1440, 13'd8191, 13'd4096);
		send_color(13'd2400, 13'd4096, 13'd8191);
		send_color(13'd3360, 13'd8191, 13'd8191);
		send_color(13'd4320, 13'd1,    13'd1);
		send_color(13'd5280, 13'd4096, 13'd0);
		send_color(13'd240,  13'd1,    13'd4096);
		send_color(13'd2000, 13'd4095, 13'd4095);
		send_color(13'd5000, 13'd2730, 13'd4096);

		quiet = 1'b0;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 0)
				quiet = ($urandom_range(0, 2) == 0);
			if (i == RANDOM_ITEMS / 2)
				drain();
			send_color(pick_hue(), pick_level(), pick_level());
			if (i < RANDOM_ITEMS - QUIET_TAIL && !quiet && $urandom_range(0, 4) == 0)
				idle_for($urandom_range(1, 8));
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d colors: all six sectors and their edges, wrapped hues,",
			colors_sent);
		$display("zero, full and over-range saturation and brightness; %0d results compared.",
			results_checked);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- files.f -----
design/hsv2rgb_pkg.sv
design/hsv_to_rgb_converter.sv
bench/hsv_to_rgb_converter_checker.sv
bench/hsv_to_rgb_converter_tb.sv
